>>> rtl/sgbs_pkg.sv
// ----------------------------------------------------------------------------
// sgbs_pkg
// Shared constants and types of the single-Gaussian background subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

package sgbs_pkg;

    localparam int PIXELS_MAX  = 1048576;
    localparam int ADDR_W      = $clog2(PIXELS_MAX);
    localparam int FRAME_W     = 21;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 21;

    localparam int MEAN_W      = 24;
    localparam int VAR_W       = 32;

    localparam int ST_DIV0     = 5;
    localparam int DIV_STEPS   = 32;
    localparam int ST_FIN      = ST_DIV0 + DIV_STEPS;
    localparam int PIPE_DEPTH  = ST_FIN + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_PIXELS = 3'd0,
        CFG_TRAIN_FRAMES = 3'd1,
        CFG_THRESHOLD    = 3'd2,
        CFG_MEAN_RATE    = 3'd3,
        CFG_VAR_RATE     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [7:0]        pixel;
        logic              train;
        logic              first;
        logic              fin;
        logic              last;
        logic              fg;
        logic [MEAN_W-1:0] mean;
        logic [VAR_W-1:0]  vr;
        logic [24:0]       s;
        logic [32:0]       q;
        logic [15:0]       dd;
        logic [23:0]       dev;
        logic [56:0]       x;
        logic [56:0]       y;
        logic [32:0]       z;
        logic [40:0]       rem_m;
        logic [56:0]       rem_v;
        logic [31:0]       quo_m;
        logic [31:0]       quo_v;
        logic              ovf_m;
        logic              ovf_v;
        logic [MEAN_W-1:0] wr_m;
        logic [VAR_W-1:0]  wr_v;
    } t_item;

endpackage

`default_nettype wire

>>> rtl/sgbs_ram.sv
// ----------------------------------------------------------------------------
// sgbs_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sgbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/single_gaussian_background_subtract_core.sv
// ----------------------------------------------------------------------------
// single_gaussian_background_subtract_core
// Per-pixel running mean and variance background model with foreground mask.
// ----------------------------------------------------------------------------
// Each accepted pixel passes the input stage, 37 further pipeline stages and
// then the output register. Throughput: one item per cycle while frame_pixels
// exceeds 38 and the output is not stalled; smaller frames accept a new pixel
// only once the pipeline holds no item, so each entry is written back first.
// Synchronous active-low reset clears the position, frame count, model state
// and pipeline valid bits; the mean and variance memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module single_gaussian_background_subtract_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [sgbs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sgbs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [7:0]                       i_pixel,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_foreground,
    output logic                                  o_training,
    output logic                                  o_frame_end
);

    import sgbs_pkg::*;

    logic [FRAME_W-1:0] r_frame_pixels;
    logic [7:0]         r_train_frames;
    logic [11:0]        r_threshold;
    logic [15:0]        r_mean_rate;
    logic [15:0]        r_var_rate;
    logic [23:0]        r_thr_sq;

    logic [ADDR_W-1:0]  r_pos;
    logic [7:0]         r_frames_seen;
    logic               r_ready;

    t_item              r_pipe [1:PIPE_DEPTH];
    t_item              n_pipe [1:PIPE_DEPTH];
    logic [1:PIPE_DEPTH] r_vld;

    logic [MEAN_W-1:0]  w_ram_m;
    logic [VAR_W-1:0]   w_ram_v;

    logic [FRAME_W-1:0] w_frame;
    logic [FRAME_W-1:0] w_frame_m1;
    logic [7:0]         w_n;
    logic               w_last;
    logic               w_small;
    logic               w_adv;
    logic               w_accept;
    logic               w_wr_en;
    logic [8:0]         w_fs_inc;
    logic [16:0]        w_mw;
    logic [16:0]        w_vw;
    logic [23:0]        w_p16;

    always_comb begin
        if (r_frame_pixels == '0) begin
            w_frame = FRAME_W'(1);
        end else if (r_frame_pixels > FRAME_W'(PIXELS_MAX)) begin
            w_frame = FRAME_W'(PIXELS_MAX);
        end else begin
            w_frame = r_frame_pixels;
        end
    end

    assign w_frame_m1 = w_frame - FRAME_W'(1);
    assign w_n        = (r_train_frames < 8'd2) ? 8'd2 : r_train_frames;
    assign w_last     = {1'b0, r_pos} >= w_frame_m1;
    assign w_small    = w_frame <= FRAME_W'(PIPE_DEPTH);
    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv && !(w_small && (|r_vld));
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_wr_en    = w_adv && r_vld[PIPE_DEPTH];
    assign w_fs_inc   = {1'b0, r_frames_seen} + 9'd1;
    assign w_mw       = 17'h10000 - 17'(r_mean_rate);
    assign w_vw       = 17'h10000 - 17'(r_var_rate);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pixels <= FRAME_W'(307200);
            r_train_frames <= 8'd30;
            r_threshold    <= 12'd768;
            r_mean_rate    <= 16'd3277;
            r_var_rate     <= 16'd1311;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FRAME_PIXELS: r_frame_pixels <= i_cfg_data;
                CFG_TRAIN_FRAMES: r_train_frames <= i_cfg_data[7:0];
                CFG_THRESHOLD:    r_threshold    <= i_cfg_data[11:0];
                CFG_MEAN_RATE:    r_mean_rate    <= i_cfg_data[15:0];
                CFG_VAR_RATE:     r_var_rate     <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr_sq <= 24'(r_threshold) * 24'(r_threshold);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_frames_seen <= '0;
            r_ready       <= 1'b0;
        end else if (w_accept) begin
            if (w_last) begin
                r_pos <= '0;
                if (!r_ready) begin
                    r_frames_seen <= w_fs_inc[7:0];
                    if ((w_fs_inc[7:0] >= w_n) || (w_fs_inc[7:0] == 8'd0)) begin
                        r_ready <= 1'b1;
                    end
                end
            end else begin
                r_pos <= r_pos + ADDR_W'(1);
            end
        end
    end

    sgbs_ram #(.WIDTH(MEAN_W), .DEPTH(PIXELS_MAX)) u_mean_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_pipe[PIPE_DEPTH].addr),
        .i_wr_data (r_pipe[PIPE_DEPTH].wr_m),
        .i_rd_en   (w_adv),
        .i_rd_addr (r_pos),
        .o_rd_data (w_ram_m)
    );

    sgbs_ram #(.WIDTH(VAR_W), .DEPTH(PIXELS_MAX)) u_var_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_pipe[PIPE_DEPTH].addr),
        .i_wr_data (r_pipe[PIPE_DEPTH].wr_v),
        .i_rd_en   (w_adv),
        .i_rd_addr (r_pos),
        .o_rd_data (w_ram_v)
    );

    always_comb begin
        n_pipe[1]       = '0;
        n_pipe[1].addr  = r_pos;
        n_pipe[1].pixel = i_pixel;
        n_pipe[1].train = !r_ready;
        n_pipe[1].first = r_frames_seen == 8'd0;
        n_pipe[1].fin   = w_fs_inc >= {1'b0, w_n};
        n_pipe[1].last  = w_last;

        for (int k = 1; k < PIPE_DEPTH; k++) begin
            n_pipe[k+1] = r_pipe[k];
            w_p16 = {r_pipe[k].pixel, 16'h0000};
            if (k == 1) begin
                if (r_pipe[k].train) begin
                    n_pipe[k+1].s = 25'(r_pipe[k].pixel)
                        + (r_pipe[k].first ? 25'd0 : 25'(w_ram_m));
                    n_pipe[k+1].q = 33'(16'(r_pipe[k].pixel) * 16'(r_pipe[k].pixel))
                        + (r_pipe[k].first ? 33'd0 : 33'(w_ram_v));
                    n_pipe[k+1].wr_m = n_pipe[k+1].s[23:0];
                    n_pipe[k+1].wr_v = n_pipe[k+1].q[31:0];
                end else begin
                    n_pipe[k+1].mean = w_ram_m;
                    n_pipe[k+1].vr   = w_ram_v;
                    n_pipe[k+1].dev  = (w_p16 > w_ram_m) ? w_p16 - w_ram_m
                                                         : w_ram_m - w_p16;
                end
            end
            if (r_pipe[k].train && r_pipe[k].fin) begin
                if (k == 2) begin
                    n_pipe[k+1].x     = 57'(41'(w_n) * 41'(r_pipe[k].q));
                    n_pipe[k+1].y     = 57'(50'(r_pipe[k].s) * 50'(r_pipe[k].s));
                    n_pipe[k+1].rem_m = (41'(r_pipe[k].s) << 16) + 41'(w_n >> 1);
                    n_pipe[k+1].dd    = 16'(w_n) * 16'(w_n - 8'd1);
                end
                if (k == 3) begin
                    n_pipe[k+1].rem_v = (r_pipe[k].x > r_pipe[k].y)
                        ? ((r_pipe[k].x - r_pipe[k].y) << 16) + 57'(r_pipe[k].dd >> 1)
                        : 57'd0;
                end
                if (k == 4) begin
                    n_pipe[k+1].ovf_m = r_pipe[k].rem_m >= (41'(w_n) << 24);
                    n_pipe[k+1].ovf_v = r_pipe[k].rem_v >= (57'(r_pipe[k].dd) << 32);
                end
                if (k >= ST_DIV0 && k < ST_FIN) begin
                    if (r_pipe[k].rem_m >= (41'(w_n) << (ST_FIN - 1 - k))) begin
                        n_pipe[k+1].rem_m = r_pipe[k].rem_m
                            - (41'(w_n) << (ST_FIN - 1 - k));
                        n_pipe[k+1].quo_m[5'(ST_FIN - 1 - k)] = 1'b1;
                    end
                    if (r_pipe[k].rem_v >= (57'(r_pipe[k].dd) << (ST_FIN - 1 - k))) begin
                        n_pipe[k+1].rem_v = r_pipe[k].rem_v
                            - (57'(r_pipe[k].dd) << (ST_FIN - 1 - k));
                        n_pipe[k+1].quo_v[5'(ST_FIN - 1 - k)] = 1'b1;
                    end
                end
                if (k == ST_FIN) begin
                    n_pipe[k+1].wr_m = r_pipe[k].ovf_m ? '1 : r_pipe[k].quo_m[23:0];
                    n_pipe[k+1].wr_v = r_pipe[k].ovf_v ? '1 : r_pipe[k].quo_v;
                end
            end
            if (!r_pipe[k].train) begin
                if (k == 2) begin
                    n_pipe[k+1].x = 57'(48'(r_pipe[k].dev) * 48'(r_pipe[k].dev));
                    n_pipe[k+1].y = 57'(56'(r_thr_sq) * 56'(r_pipe[k].vr));
                end
                if (k == 3) begin
                    n_pipe[k+1].fg = r_pipe[k].x > r_pipe[k].y;
                    n_pipe[k+1].x  = 57'(41'(w_mw) * 41'(r_pipe[k].mean));
                    n_pipe[k+1].y  = 57'(41'(r_mean_rate) * 41'(w_p16));
                end
                if (k == 4) begin
                    n_pipe[k+1].mean = 24'((r_pipe[k].x + r_pipe[k].y + 57'd32768) >> 16);
                end
                if (k == 5) begin
                    n_pipe[k+1].dev = (w_p16 > r_pipe[k].mean) ? w_p16 - r_pipe[k].mean
                                                               : r_pipe[k].mean - w_p16;
                end
                if (k == 6) begin
                    n_pipe[k+1].x = 57'(48'(r_pipe[k].dev) * 48'(r_pipe[k].dev));
                    n_pipe[k+1].y = 57'(49'(w_vw) * 49'(r_pipe[k].vr));
                end
                if (k == 7) begin
                    n_pipe[k+1].z = 33'((r_pipe[k].x + 57'd32768) >> 16);
                end
                if (k == 8) begin
                    n_pipe[k+1].x = 57'(49'(r_var_rate) * 49'(r_pipe[k].z));
                end
                if (k == 9) begin
                    n_pipe[k+1].wr_m = r_pipe[k].mean;
                    n_pipe[k+1].wr_v = 32'((r_pipe[k].x + r_pipe[k].y + 57'd32768) >> 16);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 1; k <= PIPE_DEPTH; k++) begin
                r_pipe[k] <= n_pipe[k];
            end
            o_foreground <= r_pipe[PIPE_DEPTH].fg;
            o_training   <= r_pipe[PIPE_DEPTH].train;
            o_frame_end  <= r_pipe[PIPE_DEPTH].last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            o_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld       <= {w_accept, r_vld[1:PIPE_DEPTH-1]};
            o_out_valid <= r_vld[PIPE_DEPTH];
        end
    end

    a_no_raw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_wr_en) |-> (r_pos != r_pipe[PIPE_DEPTH].addr))
        else $error("stored entry read while its update is still in flight");

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(r_vld))
        else $error("pipeline moved while the output item was stalled");

    a_model_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |=> r_ready)
        else $error("background model left the ready state");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// Background subtractor testbench
// Trains the per-pixel model on small frames and then streams pixels under
// varying frame sizes, thresholds and learning rates. Both channels pause at
// random. Each result is compared with fixed values or an in-bench model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import sgbs_pkg::*;

    typedef struct packed {
        logic fg;
        logic training;
        logic frame_end;
    } t_mask_bits;

    typedef struct packed {
        logic [7:0] pixel;
        t_mask_bits want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_pixel = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_foreground;
    logic                  o_training;
    logic                  o_frame_end;

    single_gaussian_background_subtract_core dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    longint unsigned mean_mem[int];
    longint unsigned var_mem[int];
    longint unsigned frame_size_reg, train_reg, thresh_reg, mrate_reg, vrate_reg;
    int unsigned     position, frames_done;
    bit              bg_ready;

    t_mask_bits mask_queue[$];
    int         mismatches = 0;
    int         idle_cycles = 0;
    int         burst_left = 0;
    logic [7:0] scene[64];
    t_row       rows[24];

    function automatic longint unsigned blend(longint unsigned old_v,
                                              longint unsigned fresh,
                                              longint unsigned rate);
        return ((65536 - rate) * old_v + rate * fresh + 32768) >> 16;
    endfunction

    function automatic t_mask_bits classify_pixel(logic [7:0] pix);
        longint unsigned p16, frame, n, m, v, s, q, dev, e, e2, nq, ss, d;
        int unsigned     idx;
        bit              last;
        t_mask_bits      r;
        p16 = longint'(pix) << 16;
        frame = frame_size_reg;
        n = (train_reg < 2) ? 2 : train_reg;
        idx = position;
        r = '0;
        if (frame < 1) frame = 1;
        if (frame > PIXELS_MAX) frame = PIXELS_MAX;
        if (idx >= PIXELS_MAX) idx = 0;
        last = position >= frame - 1;
        if (!bg_ready) begin
            s = pix;
            q = pix * pix;
            if (frames_done != 0) begin
                s += mean_mem[idx];
                q += var_mem[idx];
            end
            if (frames_done + 1 >= n) begin
                m = (s * 65536 + n / 2) / n;
                nq = n * q;
                ss = s * s;
                d = n * (n - 1);
                v = (nq > ss) ? ((nq - ss) * 65536 + d / 2) / d : 0;
                if (m > 64'hFFFFFF) m = 64'hFFFFFF;
                if (v > 64'hFFFFFFFF) v = 64'hFFFFFFFF;
                mean_mem[idx] = m;
                var_mem[idx] = v;
            end else begin
                mean_mem[idx] = s & 64'hFFFFFF;
                var_mem[idx] = q & 64'hFFFFFFFF;
            end
        end else begin
            m = mean_mem[idx];
            v = var_mem[idx];
            dev = (p16 > m) ? p16 - m : m - p16;
            r.fg = (dev * dev > thresh_reg * thresh_reg * v);
            m = blend(m, p16, mrate_reg);
            e = (p16 > m) ? p16 - m : m - p16;
            e2 = (e * e + 32768) >> 16;
            v = blend(v, e2, vrate_reg);
            mean_mem[idx] = m & 64'hFFFFFF;
            var_mem[idx] = v & 64'hFFFFFFFF;
        end
        r.training = !bg_ready;
        r.frame_end = last;
        if (last) begin
            position = 0;
            if (!bg_ready) begin
                frames_done = (frames_done + 1) & 8'hFF;
                if (frames_done >= n || frames_done == 0) bg_ready = 1'b1;
            end
        end else begin
            position = (position + 1) & 20'hFFFFF;
        end
        return r;
    endfunction

    task automatic write_reg(t_cfg_idx idx, longint unsigned value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_FRAME_PIXELS: frame_size_reg = value & 21'h1FFFFF;
            CFG_TRAIN_FRAMES: train_reg = value & 8'hFF;
            CFG_THRESHOLD:    thresh_reg = value & 12'hFFF;
            CFG_MEAN_RATE:    mrate_reg = value & 16'hFFFF;
            CFG_VAR_RATE:     vrate_reg = value & 16'hFFFF;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic end_writes();
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (mask_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [7:0] pix, bit typed, t_mask_bits want);
        t_mask_bits predicted;
        int         gap;
        i_in_valid <= 1'b1;
        i_pixel <= pix;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = classify_pixel(pix);
        mask_queue.push_back(typed ? want : predicted);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    function automatic logic [7:0] scene_pixel(int unsigned pos, bit noisy);
        int v;
        if (noisy && $urandom_range(0, 6) == 0) return 8'($urandom);
        v = int'(scene[pos % 64]) + $urandom_range(0, 12) - 6;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    int stall_mode = 0;
    int stall_count = 0;
    always @(posedge i_clk) begin
        t_mask_bits got, want;
        if (o_out_valid && i_out_ready) begin
            got = '{o_foreground, o_training, o_frame_end};
            if (mask_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result item %b", got);
            end else begin
                want = mask_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: fg %b/%b training %b/%b frame_end %b/%b",
                                 want.fg, got.fg, want.training, got.training,
                                 want.frame_end, got.frame_end);
                end
            end
        end
        if (stall_count == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_count = $urandom_range(16, 96);
        end else begin
            stall_count--;
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            2: i_out_ready <= stall_count[2];
            default: i_out_ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= 5000) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    int unsigned phase_frame[8] = '{64, 64, 64, 40, 21, 13, 5, 0};

    initial begin
        frame_size_reg = 307200;
        train_reg = 30;
        thresh_reg = 768;
        mrate_reg = 3277;
        vrate_reg = 1311;
        position = 0;
        frames_done = 0;
        bg_ready = 1'b0;
        for (int i = 0; i < 64; i++) scene[i] = 8'($urandom);
        for (int i = 0; i < 4; i++) scene[i] = 8'd255;
        for (int i = 4; i < 8; i++) scene[i] = 8'd0;
        for (int i = 0; i < 24; i++) begin
            rows[i].pixel = (i < 8) ? ((i < 4) ? 8'd255 : 8'd0) : 8'(1 << (i % 8));
            if (i >= 16) rows[i].pixel = ~rows[i].pixel;
            rows[i].want = '{1'b0, 1'b1, 1'b0};
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(CFG_FRAME_PIXELS, 0);
        write_reg(CFG_FRAME_PIXELS, 21'h1FFFFF);
        write_reg(CFG_FRAME_PIXELS, PIXELS_MAX);
        write_reg(CFG_TRAIN_FRAMES, 0);
        write_reg(CFG_TRAIN_FRAMES, 255);
        write_reg(CFG_THRESHOLD, 4095);
        write_reg(CFG_MEAN_RATE, 65535);
        write_reg(CFG_VAR_RATE, 0);
        write_reg(CFG_FRAME_PIXELS, 64);
        write_reg(CFG_TRAIN_FRAMES, 4);
        write_reg(CFG_THRESHOLD, 768);
        write_reg(CFG_MEAN_RATE, 3277);
        write_reg(CFG_VAR_RATE, 1311);
        end_writes();

        foreach (rows[i]) send_pixel(rows[i].pixel, 1'b1, rows[i].want);
        for (int i = 24; i < 128; i++) send_pixel(scene_pixel(i, 1'b1), 1'b0, '0);

        // Lowering the frame count here leaves three frames of sums for N of two.
        wait_idle();
        write_reg(CFG_TRAIN_FRAMES, 2);
        end_writes();
        for (int i = 0; i < 64; i++) send_pixel(scene_pixel(i, 1'b1), 1'b0, '0);

        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            write_reg(CFG_FRAME_PIXELS, phase_frame[ph]);
            case (ph)
                1: begin
                    write_reg(CFG_THRESHOLD, 0);
                    write_reg(CFG_MEAN_RATE, 65535);
                    write_reg(CFG_VAR_RATE, 65535);
                end
                2: begin
                    write_reg(CFG_THRESHOLD, 4095);
                    write_reg(CFG_MEAN_RATE, 0);
                    write_reg(CFG_VAR_RATE, 0);
                end
                0: ;
                default: begin
                    write_reg(CFG_THRESHOLD, $urandom_range(256, 1200));
                    write_reg(CFG_MEAN_RATE, $urandom_range(0, 65535));
                    write_reg(CFG_VAR_RATE, $urandom_range(0, 65535));
                    write_reg(CFG_TRAIN_FRAMES, $urandom_range(0, 255));
                end
            endcase
            end_writes();
            repeat ($urandom_range(150, 230))
                send_pixel(scene_pixel(position, 1'b1), 1'b0, '0);
        end

        wait_idle();
        repeat (60) @(posedge i_clk);
        if (mask_queue.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
